FILE: hdl/bfc_pkg.sv
// Shared constants and register codes for the banked FIR convolver.
// Used by the request and result interfaces and by the top level.
package bfc_pkg;

    localparam int MAX_TAPS_DEF  = 1024;
    localparam int NUM_BANKS_DEF = 8;
    localparam int BYPASS_BELOW  = 3;

    localparam int SAMPLE_W   = 24;
    localparam int BANK_W     = 3;
    localparam int INDEX_W    = 10;
    localparam int TAPS_W     = 11;
    localparam int GAIN_W     = 16;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    localparam int PROD_W     = 2 * SAMPLE_W;
    localparam int ACC_W      = 64;
    localparam int FRAC_W     = 23;
    localparam int GAIN_FRAC  = 12;
    localparam int SCALED_W   = 37;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_COEF   = 1'b1;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd4096;

    localparam logic signed [ACC_W-1:0] ROUND_HALF  = 64'sd1 <<< (FRAC_W - 1);
    localparam logic signed [ACC_W-1:0] GAIN_HALF   = 64'sd1 <<< (GAIN_FRAC - 1);
    localparam logic signed [ACC_W-1:0] SCALED_MAX  = (64'sd1 <<< (SCALED_W - 1)) - 64'sd1;
    localparam logic signed [ACC_W-1:0] SCALED_MIN  = -(64'sd1 <<< (SCALED_W - 1));
    localparam logic signed [ACC_W-1:0] OUT_MAX     = (64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1;
    localparam logic signed [ACC_W-1:0] OUT_MIN     = -(64'sd1 <<< (SAMPLE_W - 1));

    typedef enum logic [1:0] {
        REG_BANK_SELECT = 2'd0,
        REG_TAP_COUNT   = 2'd1,
        REG_OUTPUT_GAIN = 2'd2
    } reg_idx_t;

endpackage

FILE: hdl/bfc_ifs.sv
// Request and result channel interfaces of the banked FIR convolver.
// Depends on bfc_pkg for the field widths.
interface bfc_req_if import bfc_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic                       operation;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic [BANK_W-1:0]          coef_bank;
    logic [INDEX_W-1:0]         coef_index;
    logic signed [SAMPLE_W-1:0] coef_value;

    modport source (output valid, operation, sample_in, coef_bank, coef_index, coef_value,
                    input ready);
    modport sink (input valid, operation, sample_in, coef_bank, coef_index, coef_value,
                  output ready);
endinterface

interface bfc_res_if import bfc_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_out;

    modport source (output valid, sample_out, input ready);
    modport sink (input valid, sample_out, output ready);
endinterface

FILE: hdl/bfc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module bfc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/banked_fir_convolver.sv
// Banked FIR convolver top level: APB registers, sequencer, shared MAC datapath.
// Depends on bfc_pkg, bfc_req_if, bfc_res_if and bfc_ram.
//
// Channel   Dir  Handshake             Contents
// request   in   valid/ready           operation, sample_in, coef_bank, coef_index, coef_value
// result    out  valid/ready           sample_out
// apb       in   psel/penable/pready   bank_select, tap_count, output_gain
//
// Between one filtered sample's request and the earliest next one, the single multiplier
// handles one tap per cycle over the tap length (tap_count capped at MAX_TAPS), followed
// by the pipeline drain, the rounding and the two gain products.
// Bypassed samples and coefficient writes are handled in the idle state itself.
// After reset all MAX_TAPS history entries are cleared with request.ready low.
// A finished result is held in the output register until the result channel takes it.
module banked_fir_convolver import bfc_pkg::*; #(
    parameter int MAX_TAPS  = MAX_TAPS_DEF,
    parameter int NUM_BANKS = NUM_BANKS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    bfc_req_if.sink               request,
    bfc_res_if.source             result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int POS_W   = $clog2(MAX_TAPS);
    localparam int LEN_W   = $clog2(MAX_TAPS + 1);
    localparam int CDEPTH  = NUM_BANKS * MAX_TAPS;
    localparam int CADDR_W = $clog2(CDEPTH);

    typedef enum logic [8:0] {
        S_CLEAR    = 9'b000000001,
        S_IDLE     = 9'b000000010,
        S_RUN      = 9'b000000100,
        S_DRAIN    = 9'b000001000,
        S_ROUND    = 9'b000010000,
        S_SCALE_HI = 9'b000100000,
        S_SCALE_LO = 9'b001000000,
        S_FINISH   = 9'b010000000,
        S_DONE     = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [BANK_W-1:0] bank_select_reg;
    logic [TAPS_W-1:0] tap_count_reg;
    logic [GAIN_W-1:0] output_gain_reg;

    logic              cfg_wr;
    reg_idx_t          cfg_idx;

    logic [LEN_W-1:0]  len;
    logic [POS_W-1:0]  pos;
    logic              bypass;
    logic              bank_ok;
    logic [CADDR_W-1:0] bank_base;
    logic              req_acc;
    logic              coef_ok;
    logic              out_free;

    logic [POS_W-1:0]   wp_reg, wp_next;
    logic [POS_W-1:0]   clr_reg, clr_next;
    logic [LEN_W-1:0]   cnt_reg, cnt_next;
    logic [POS_W-1:0]   idx_reg, idx_next;
    logic [CADDR_W-1:0] caddr_reg, caddr_next;
    logic               bank_ok_reg, bank_ok_next;
    logic               rd_vld_reg, rd_vld_next;
    logic               mul_vld_reg;
    logic               shift_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic signed [SCALED_W-1:0] s_reg, s_next;
    logic               out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_data_reg;

    logic               hist_we;
    logic [POS_W-1:0]   hist_waddr;
    logic [SAMPLE_W-1:0] hist_wdata;
    logic [SAMPLE_W-1:0] hist_rdata;
    logic               coef_we;
    logic [CADDR_W-1:0] coef_waddr;
    logic [SAMPLE_W-1:0] coef_rdata;

    logic               mul_en;
    logic               shift_next;
    logic signed [SAMPLE_W-1:0] op_a;
    logic signed [SAMPLE_W-1:0] op_b;
    logic signed [ACC_W-1:0]    acc_add;
    logic signed [ACC_W-1:0]    s_sum;
    logic signed [ACC_W-1:0]    s_full;
    logic signed [ACC_W-1:0]    y_full;
    logic signed [SAMPLE_W-1:0] y_sat;
    logic               load_out;
    logic signed [SAMPLE_W-1:0] out_value;

    // Configuration registers.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_select_reg <= '0;
            tap_count_reg   <= '0;
            output_gain_reg <= GAIN_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_BANK_SELECT: bank_select_reg <= pwdata[BANK_W-1:0];
                REG_TAP_COUNT:   tap_count_reg   <= pwdata[TAPS_W-1:0];
                REG_OUTPUT_GAIN: output_gain_reg <= pwdata[GAIN_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_BANK_SELECT: prdata = APB_DATA_W'(bank_select_reg);
            REG_TAP_COUNT:   prdata = APB_DATA_W'(tap_count_reg);
            REG_OUTPUT_GAIN: prdata = APB_DATA_W'(output_gain_reg);
            default:         prdata = '0;
        endcase
    end

    // Request decode.
    assign len       = (32'(tap_count_reg) > MAX_TAPS) ? LEN_W'(MAX_TAPS)
                                                       : LEN_W'(tap_count_reg);
    assign pos       = (LEN_W'(wp_reg) < len) ? wp_reg : '0;
    assign bypass    = 32'(len) < BYPASS_BELOW;
    assign bank_ok   = 32'(bank_select_reg) < NUM_BANKS;
    assign bank_base = bank_ok ? CADDR_W'(32'(bank_select_reg) * MAX_TAPS) : '0;
    assign out_free  = !out_valid_reg || result.ready;
    assign req_acc   = request.valid && request.ready;
    assign coef_ok   = (32'(request.coef_bank) < NUM_BANKS) &&
                       (32'(request.coef_index) < MAX_TAPS);

    assign request.ready = (state_reg == S_IDLE) && out_free;

    assign coef_we    = req_acc && (request.operation == OP_COEF) && coef_ok;
    assign coef_waddr = CADDR_W'(32'(request.coef_bank) * MAX_TAPS + 32'(request.coef_index));

    bfc_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_TAPS)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .raddr (idx_reg),
        .rdata (hist_rdata)
    );

    bfc_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (CDEPTH)
    ) u_coef_ram (
        .clk   (clk),
        .we    (coef_we),
        .waddr (coef_waddr),
        .wdata (request.coef_value),
        .raddr (caddr_reg),
        .rdata (coef_rdata)
    );

    // Shared multiplier: taps first, then the gain in two partial products.
    always_comb
    begin
        mul_en     = 1'b0;
        shift_next = 1'b0;
        op_a       = '0;
        op_b       = '0;
        if (rd_vld_reg)
        begin
            mul_en = 1'b1;
            op_a   = bank_ok_reg ? coef_rdata : '0;
            op_b   = hist_rdata;
        end
        else if (state_reg == S_SCALE_HI)
        begin
            mul_en     = 1'b1;
            shift_next = 1'b1;
            op_a = {{(SAMPLE_W - SCALED_W + FRAC_W){s_reg[SCALED_W-1]}},
                    s_reg[SCALED_W-1:FRAC_W]};
            op_b = {{(SAMPLE_W - GAIN_W){1'b0}}, output_gain_reg};
        end
        else if (state_reg == S_SCALE_LO)
        begin
            mul_en = 1'b1;
            op_a   = {{(SAMPLE_W - FRAC_W){1'b0}}, s_reg[FRAC_W-1:0]};
            op_b   = {{(SAMPLE_W - GAIN_W){1'b0}}, output_gain_reg};
        end
    end

    assign acc_add = shift_reg ? (ACC_W'(prod_reg) <<< FRAC_W) : ACC_W'(prod_reg);
    assign s_sum   = acc_reg + ROUND_HALF;
    assign s_full  = s_sum >>> FRAC_W;
    assign y_full  = acc_reg >>> GAIN_FRAC;

    always_comb
    begin
        if (y_full > OUT_MAX)
        begin
            y_sat = SAMPLE_W'(OUT_MAX);
        end
        else if (y_full < OUT_MIN)
        begin
            y_sat = SAMPLE_W'(OUT_MIN);
        end
        else
        begin
            y_sat = SAMPLE_W'(y_full);
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        caddr_next   = caddr_reg;
        bank_ok_next = bank_ok_reg;
        rd_vld_next  = 1'b0;
        wp_next      = wp_reg;
        clr_next     = clr_reg;
        s_next       = s_reg;
        hist_we      = 1'b0;
        hist_waddr   = clr_reg;
        hist_wdata   = '0;
        load_out     = 1'b0;
        out_value    = '0;
        acc_next     = mul_vld_reg ? acc_reg + acc_add : acc_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                hist_we = 1'b1;
                if (clr_reg == POS_W'(MAX_TAPS - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + POS_W'(1);
                end
            end
            S_IDLE:
            begin
                if (req_acc && (request.operation == OP_SAMPLE))
                begin
                    if (bypass)
                    begin
                        load_out  = 1'b1;
                        out_value = request.sample_in;
                    end
                    else
                    begin
                        hist_we      = 1'b1;
                        hist_waddr   = pos;
                        hist_wdata   = request.sample_in;
                        wp_next      = (LEN_W'(pos) + LEN_W'(1) >= len) ? '0
                                                                        : pos + POS_W'(1);
                        idx_next     = pos;
                        cnt_next     = '0;
                        caddr_next   = bank_base;
                        bank_ok_next = bank_ok;
                        acc_next     = '0;
                        state_next   = S_RUN;
                    end
                end
            end
            S_RUN:
            begin
                rd_vld_next = 1'b1;
                caddr_next  = caddr_reg + CADDR_W'(1);
                idx_next    = (idx_reg == '0) ? POS_W'(len - LEN_W'(1)) : idx_reg - POS_W'(1);
                if (cnt_reg == len - LEN_W'(1))
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + LEN_W'(1);
                end
            end
            S_DRAIN:
            begin
                if (!rd_vld_reg && !mul_vld_reg)
                begin
                    state_next = S_ROUND;
                end
            end
            S_ROUND:
            begin
                if (s_full > SCALED_MAX)
                begin
                    s_next = SCALED_W'(SCALED_MAX);
                end
                else if (s_full < SCALED_MIN)
                begin
                    s_next = SCALED_W'(SCALED_MIN);
                end
                else
                begin
                    s_next = SCALED_W'(s_full);
                end
                acc_next   = GAIN_HALF;
                state_next = S_SCALE_HI;
            end
            S_SCALE_HI:
            begin
                state_next = S_SCALE_LO;
            end
            S_SCALE_LO:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!mul_vld_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    out_value  = y_sat;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            wp_reg        <= '0;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            caddr_reg     <= '0;
            bank_ok_reg   <= 1'b0;
            rd_vld_reg    <= 1'b0;
            mul_vld_reg   <= 1'b0;
            shift_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            wp_reg      <= wp_next;
            cnt_reg     <= cnt_next;
            idx_reg     <= idx_next;
            caddr_reg   <= caddr_next;
            bank_ok_reg <= bank_ok_next;
            rd_vld_reg  <= rd_vld_next;
            mul_vld_reg <= mul_en;
            shift_reg   <= shift_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
        acc_reg  <= acc_next;
        s_reg    <= s_next;
        if (load_out)
        begin
            out_data_reg <= out_value;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.sample_out = out_data_reg;

`ifndef NO_ASSERTIONS
    a_result_source : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> ($past(state_reg) == S_IDLE || $past(state_reg) == S_DONE))
        else $error("result raised outside idle or done");

    a_index_range : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) |-> (LEN_W'(idx_reg) < len))
        else $error("history index beyond tap length");

    a_pipe_empty : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROUND) |-> (!rd_vld_reg && !mul_vld_reg))
        else $error("rounding started with taps still in flight");

    a_no_request_in_clear : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !request.ready)
        else $error("request taken during history clear");

    a_run_entry : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN && $past(state_reg) == S_IDLE) |-> (cnt_reg == '0))
        else $error("tap counter not cleared at start");
`endif

endmodule

FILE: sim/tb_banked_fir_convolver.sv
// Self-checking testbench for the banked FIR convolver: directed and random requests,
// predicted results checked in order, and APB set-up between phases.
// Depends on bfc_pkg, bfc_req_if, bfc_res_if and the banked_fir_convolver top level.
module tb_banked_fir_convolver;
    import bfc_pkg::*;

    localparam int TAP_DEPTH     = MAX_TAPS_DEF;
    localparam int COEF_DEPTH    = NUM_BANKS_DEF * MAX_TAPS_DEF;
    localparam int SETTLE_CYCLES = 32;
    localparam int LONG_STALL    = 600;
    localparam int RANDOM_ITEMS  = 580;
    localparam int MAX_TAP_REG   = 2047;

    typedef struct {
        logic                       op;
        logic signed [SAMPLE_W-1:0] smp;
        logic [BANK_W-1:0]          bank;
        logic [INDEX_W-1:0]         index;
        logic signed [SAMPLE_W-1:0] value;
    } conv_req_t;

    logic                  clk     = 1'b0;
    logic                  rst_n   = 1'b0;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    bfc_req_if request ();
    bfc_res_if result ();

    banked_fir_convolver dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic signed [SAMPLE_W-1:0] history [TAP_DEPTH];
    int unsigned                wr_pos;
    logic signed [SAMPLE_W-1:0] coef_mem [COEF_DEPTH];
    bit                         coef_planned [COEF_DEPTH];
    logic [BANK_W-1:0]          bank_sel_q;
    logic [TAPS_W-1:0]          taps_q;
    logic [GAIN_W-1:0]          gain_q;

    conv_req_t                  pending_reqs [$];
    conv_req_t                  in_flight;
    logic signed [SAMPLE_W-1:0] expected_out [$];
    logic signed [SAMPLE_W-1:0] out_want;

    int unsigned send_idle_pct = 12;
    int unsigned recv_idle_pct = 81;
    logic        hold_off      = 1'b0;
    logic        hold_go       = 1'b0;
    int          errors        = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        request.valid      = 1'b0;
        request.operation  = OP_SAMPLE;
        request.sample_in  = '0;
        request.coef_bank  = '0;
        request.coef_index = '0;
        request.coef_value = '0;
        result.ready       = 1'b0;
    end

    function automatic logic signed [SAMPLE_W-1:0] rand_q123();
        return SAMPLE_W'($signed($urandom) >>> $urandom_range(0, 16));
    endfunction

    // Applies one accepted request to the shadow state; a sample request also queues the sample it produces.
    task automatic fir_accept(input conv_req_t r);
        int unsigned len;
        int unsigned pos;
        int unsigned idx;
        longint      acc;
        longint      s;
        longint      y;
        if (r.op == OP_COEF)
        begin
            coef_mem[int'(r.bank) * TAP_DEPTH + int'(r.index)] = r.value;
            return;
        end
        len = (taps_q > TAP_DEPTH) ? TAP_DEPTH : taps_q;
        if (len < BYPASS_BELOW)
        begin
            expected_out.push_back(r.smp);
            return;
        end
        pos = (wr_pos < len) ? wr_pos : 0;
        history[pos] = r.smp;
        wr_pos = (pos + 1 >= len) ? 0 : pos + 1;
        acc = 0;
        idx = pos;
        for (int k = 0; k < len; k++)
        begin
            acc += longint'(coef_mem[int'(bank_sel_q) * TAP_DEPTH + k]) * longint'(history[idx]);
            idx = (idx == 0) ? len - 1 : idx - 1;
        end
        s = (acc + ROUND_HALF) >>> FRAC_W;
        y = (s * longint'({48'd0, gain_q}) + GAIN_HALF) >>> GAIN_FRAC;
        if (y > OUT_MAX)
            y = OUT_MAX;
        if (y < OUT_MIN)
            y = OUT_MIN;
        expected_out.push_back(SAMPLE_W'(y));
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            request.valid <= 1'b0;
        end
        else
        begin
            if (request.valid && request.ready)
                fir_accept(in_flight);
            if (!request.valid || request.ready)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_flight = pending_reqs.pop_front();
                    request.valid      <= 1'b1;
                    request.operation  <= in_flight.op;
                    request.sample_in  <= in_flight.smp;
                    request.coef_bank  <= in_flight.bank;
                    request.coef_index <= in_flight.index;
                    request.coef_value <= in_flight.value;
                end
                else
                begin
                    request.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result.ready <= 1'b0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (expected_out.size() == 0)
                begin
                    $display("%0t unexpected result %0d with nothing outstanding",
                             $time, result.sample_out);
                    errors++;
                end
                else
                begin
                    out_want = expected_out.pop_front();
                    if (result.sample_out !== out_want)
                    begin
                        $display("%0t sample_out mismatch: expected %0d, got %0d",
                                 $time, out_want, result.sample_out);
                        errors++;
                    end
                end
            end
            result.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // The result side is held off for a long stretch so that the block backs up.
    initial
    begin
        wait (hold_go);
        hold_off <= 1'b1;
        repeat (LONG_STALL) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        #40000000;
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic push_sample(input logic signed [SAMPLE_W-1:0] x);
        conv_req_t r;
        r.op    = OP_SAMPLE;
        r.smp   = x;
        r.bank  = BANK_W'($urandom);
        r.index = INDEX_W'($urandom);
        r.value = rand_q123();
        pending_reqs.push_back(r);
    endtask

    task automatic push_coef(input int unsigned bank, input int unsigned index,
                             input logic signed [SAMPLE_W-1:0] v);
        conv_req_t r;
        r.op    = OP_COEF;
        r.smp   = rand_q123();
        r.bank  = BANK_W'(bank);
        r.index = INDEX_W'(index);
        r.value = v;
        coef_planned[bank * TAP_DEPTH + index] = 1'b1;
        pending_reqs.push_back(r);
    endtask

    task automatic drain_all();
        while (pending_reqs.size() != 0 || request.valid || expected_out.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic reg_write(input reg_idx_t r, input int unsigned v);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (r)
            REG_BANK_SELECT: bank_sel_q = BANK_W'(v);
            REG_TAP_COUNT:   taps_q     = TAPS_W'(v);
            REG_OUTPUT_GAIN: gain_q     = GAIN_W'(v);
            default:         ;
        endcase
    endtask

    // Reconfigures the block once it is idle, then loads any coefficient the new
    // tap length would read before it has ever been written.
    task automatic set_filter(input int unsigned bank, input int unsigned taps,
                              input int unsigned gain);
        int unsigned len;
        drain_all();
        reg_write(REG_BANK_SELECT, bank);
        reg_write(REG_TAP_COUNT, taps);
        reg_write(REG_OUTPUT_GAIN, gain);
        len = (taps > TAP_DEPTH) ? TAP_DEPTH : taps;
        if (len >= BYPASS_BELOW)
        begin
            for (int k = 0; k < len; k++)
            begin
                if (!coef_planned[bank * TAP_DEPTH + k])
                    push_coef(bank, k, rand_q123());
            end
        end
    endtask

    initial
    begin
        int unsigned counted;
        int unsigned seg;
        int unsigned bank;
        int unsigned taps;
        int unsigned gain;
        int unsigned n;
        int unsigned pick;
        history    = '{default: '0};
        wr_pos     = 0;
        bank_sel_q = '0;
        taps_q     = '0;
        gain_q     = GAIN_RESET;
        counted    = 0;
        seg        = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        push_sample(SAMPLE_W'(OUT_MAX));
        push_sample(SAMPLE_W'(OUT_MIN));
        push_sample('0);
        push_sample(SAMPLE_W'(1));
        push_coef(NUM_BANKS_DEF - 1, TAP_DEPTH - 1, SAMPLE_W'(OUT_MIN));
        push_coef(0, 0, SAMPLE_W'(OUT_MAX));

        set_filter(0, BYPASS_BELOW, GAIN_RESET);
        for (int k = 0; k < BYPASS_BELOW; k++)
            push_coef(0, k, SAMPLE_W'(OUT_MIN));
        for (int k = 0; k < BYPASS_BELOW; k++)
            push_sample(SAMPLE_W'(OUT_MIN));
        push_sample(SAMPLE_W'(OUT_MAX));
        set_filter(0, BYPASS_BELOW, 0);
        push_sample(SAMPLE_W'(OUT_MAX));
        push_sample(rand_q123());
        set_filter(0, BYPASS_BELOW, 65535);
        push_sample(SAMPLE_W'(1));
        push_sample(SAMPLE_W'(OUT_MIN));
        set_filter(0, BYPASS_BELOW - 1, GAIN_RESET);
        push_sample(rand_q123());

        while (counted < RANDOM_ITEMS)
        begin
            drain_all();
            if (counted >= 400)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            else if (counted >= 200)
            begin
                send_idle_pct = 81;
                recv_idle_pct = 12;
            end
            bank = $urandom_range(0, NUM_BANKS_DEF - 1);
            pick = $urandom_range(99);
            if (pick < 10)
                taps = $urandom_range(0, BYPASS_BELOW - 1);
            else if (pick < 70)
                taps = $urandom_range(BYPASS_BELOW, 16);
            else
                taps = $urandom_range(17, 64);
            n = $urandom_range(12, 30);
            case (seg)
                2:
                begin
                    taps = 8;
                    n    = 60;
                end
                3:
                begin
                    bank = NUM_BANKS_DEF - 1;
                    taps = TAP_DEPTH;
                    n    = 4;
                end
                4:
                begin
                    bank = NUM_BANKS_DEF - 1;
                    taps = MAX_TAP_REG;
                    n    = 3;
                end
                9:
                begin
                    taps = 0;
                    n    = 10;
                end
                default: ;
            endcase
            pick = $urandom_range(99);
            if (pick < 10)
                gain = 0;
            else if (pick < 20)
                gain = 65535;
            else if (pick < 50)
                gain = GAIN_RESET;
            else
                gain = $urandom_range(0, 65535);
            set_filter(bank, taps, gain);
            for (int i = 0; i < n; i++)
            begin
                if ($urandom_range(9) == 0)
                    push_coef($urandom_range(0, NUM_BANKS_DEF - 1),
                              $urandom_range(0, TAP_DEPTH - 1), rand_q123());
                else if ($urandom_range(7) == 0)
                    push_sample(SAMPLE_W'($urandom));
                else
                    push_sample(rand_q123());
                counted++;
            end
            if (seg == 2)
                hold_go <= 1'b1;
            seg++;
        end

        drain_all();
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
